@@ rtl/core/power_spectrum_peak_tracker_assert.svh @@
// Assertion macros shared by the power spectrum peak tracker RTL.
`ifndef POWER_SPECTRUM_PEAK_TRACKER_ASSERT_SVH
`define POWER_SPECTRUM_PEAK_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/pst_pkg.sv @@
// Shared constants, result layout and helpers for the power spectrum peak tracker.
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;

    localparam int DEF_MAX_BINS    = 4096;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int SAMPLE_W    = 24;
    localparam int IN_TDATA_W  = 2 * SAMPLE_W;
    localparam int VALUE_W     = 48;
    localparam int INDEX_W     = 12;
    localparam int SUM_W       = 60;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [SUM_W-1:0]   total_power;
        logic [INDEX_W-1:0] floor_bin;
        logic [INDEX_W-1:0] peak_bin;
        logic [INDEX_W-1:0] bin_index;
        logic [VALUE_W-1:0] bin_value;
    } t_result;

    localparam int OUT_TDATA_W = $bits(t_result);

    // Width of one queued bin: power, index, last flag and mode.
    function automatic int item_width(input int sample_bits, input int max_bins);
        return 2 * sample_bits + $clog2(max_bins) + 2;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pst_queue.sv @@
// Short FIFO that decouples bin classification from the value/tracking back end.
`timescale 1ns / 1ps
`default_nettype none
`include "power_spectrum_peak_tracker_assert.svh"
module pst_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = pst_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `PST_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_count < CNT_W'(DEPTH), "queue push while full")
    `PST_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue pop while empty")
    `PST_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

@@ rtl/core/pst_front.sv @@
// Front end: accepts bins, squares the components and tags index, last and mode.
`timescale 1ns / 1ps
`default_nettype none
module pst_front #(
    parameter int MAX_BINS    = pst_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = pst_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH       = pst_pkg::QUEUE_DEPTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // bin_re [23:0], bin_im [47:24]
    input  wire logic [pst_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
    input  wire logic                                   s_axis_tlast,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [0:0]                             i_cfg_data,
    input  wire logic [$clog2(DEPTH+1)-1:0]             i_q_count,
    output logic                                        o_q_push,
    output logic [pst_pkg::item_width(SAMPLE_BITS, MAX_BINS)-1:0] o_q_item
);

    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_BINS);
    localparam int QCW  = $clog2(DEPTH + 1);
    localparam int SW_IN = pst_pkg::SAMPLE_W;

    typedef struct packed {
        logic          mode;
        logic          last;
        logic [CW-1:0] index;
        logic [PW-1:0] power;
    } t_bin_item;

    logic          r_mode;
    logic [CW-1:0] r_count;
    logic          r_s1_valid;
    logic [PW-1:0] r_sq_re;
    logic [PW-1:0] r_sq_im;
    logic [CW-1:0] r_s1_index;
    logic          r_s1_last;
    logic          r_s1_mode;

    logic [SB-1:0] raw_re;
    logic [SB-1:0] raw_im;
    logic [SB-1:0] abs_re;
    logic [SB-1:0] abs_im;
    logic [PW-1:0] sq_re;
    logic [PW-1:0] sq_im;
    logic [QCW:0]  slots_used;
    logic          accept;
    logic          is_last;
    t_bin_item     item;

    // Bits above SAMPLE_BITS are dropped; a short sample is taken as non-negative.
    always_comb begin
        raw_re = SB'(s_axis_tdata[SW_IN-1:0]);
        raw_im = SB'(s_axis_tdata[2*SW_IN-1:SW_IN]);
        abs_re = raw_re[SB-1] ? (~raw_re + SB'(1)) : raw_re;
        abs_im = raw_im[SB-1] ? (~raw_im + SB'(1)) : raw_im;
        sq_re  = abs_re * abs_re;
        sq_im  = abs_im * abs_im;
    end

    // Reserve a queue slot for the item in the squaring stage.
    assign slots_used    = {1'b0, i_q_count} + {{QCW{1'b0}}, r_s1_valid};
    assign s_axis_tready = (slots_used < (QCW + 1)'(DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_last       = s_axis_tlast || (r_count == CW'(MAX_BINS - 1));
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data[0];
            end
            r_s1_valid <= accept;
            if (accept) begin
                r_count <= is_last ? '0 : r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_re    <= sq_re;
            r_sq_im    <= sq_im;
            r_s1_index <= r_count;
            r_s1_last  <= is_last;
            r_s1_mode  <= r_mode;
        end
    end

    always_comb begin
        item.mode  = r_s1_mode;
        item.last  = r_s1_last;
        item.index = r_s1_index;
        item.power = r_sq_re + r_sq_im;
    end

    assign o_q_push = r_s1_valid;
    assign o_q_item = item;

endmodule
`default_nettype wire

@@ rtl/core/pst_back.sv @@
// Back end: bin value (power or root), peak/floor/total tracking and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "power_spectrum_peak_tracker_assert.svh"
module pst_back #(
    parameter int MAX_BINS    = pst_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = pst_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_q_valid,
    input  wire logic [pst_pkg::item_width(SAMPLE_BITS, MAX_BINS)-1:0] i_q_item,
    output logic                                        o_q_pop,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output pst_pkg::t_result                            o_out_data,
    output logic                                        o_out_last
);

    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_BINS);
    localparam int VW   = pst_pkg::VALUE_W;
    localparam int IW   = pst_pkg::INDEX_W;
    localparam int SUMW = pst_pkg::SUM_W;
    localparam int EW   = (PW > VW) ? PW : VW;
    localparam int SW   = ((PW > SUMW) ? PW : SUMW) + 1;

    typedef struct packed {
        logic          mode;
        logic          last;
        logic [CW-1:0] index;
        logic [PW-1:0] power;
    } t_bin_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_HOLD
    } t_state;

    t_state           r_state;
    t_bin_item        r_item;
    logic [VW-1:0]    r_val;
    logic [PW-1:0]    r_x;
    logic [PW-1:0]    r_res;
    logic [PW-1:0]    r_bit;
    logic [VW-1:0]    r_max_val;
    logic [CW-1:0]    r_max_idx;
    logic [VW-1:0]    r_min_val;
    logic [CW-1:0]    r_min_idx;
    logic [SUMW-1:0]  r_sum;
    logic             r_out_valid;
    pst_pkg::t_result r_out_data;
    logic             r_out_last;

    t_bin_item        head;
    logic [EW-1:0]    head_ext;
    logic [VW-1:0]    head_sat;
    logic [PW-1:0]    trial;
    logic             root_ge;
    logic [PW-1:0]    n_x;
    logic [PW-1:0]    n_res;
    logic             k_zero;
    logic             k_one;
    logic             take_max;
    logic             take_min;
    logic [SW-1:0]    sum_ext;
    logic [VW-1:0]    n_max_val;
    logic [CW-1:0]    n_max_idx;
    logic [VW-1:0]    n_min_val;
    logic [CW-1:0]    n_min_idx;
    logic [SUMW-1:0]  n_sum;
    logic             out_free;
    logic             fire;
    pst_pkg::t_result n_out_data;

    assign head = i_q_item;

    always_comb begin
        head_ext = EW'(head.power);
        head_sat = (head_ext > EW'(pst_pkg::VALUE_MAX)) ? pst_pkg::VALUE_MAX : VW'(head_ext);
    end

    // One result bit per cycle of the digit-by-digit square root.
    always_comb begin
        trial   = r_res + r_bit;
        root_ge = (r_x >= trial);
        n_x     = root_ge ? (r_x - trial) : r_x;
        n_res   = root_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    always_comb begin
        k_zero   = (r_item.index == '0);
        k_one    = (r_item.index == CW'(1));
        take_max = k_zero || (r_val > r_max_val);
        // Power mode leaves DC out of the floor search.
        if (r_item.mode) begin
            take_min = k_zero || (r_val < r_min_val);
        end else begin
            take_min = k_one || (!k_zero && (r_val < r_min_val));
        end
        sum_ext   = SW'(r_sum) + SW'(r_item.power);
        n_max_val = take_max ? r_val : r_max_val;
        n_max_idx = take_max ? r_item.index : r_max_idx;
        n_min_val = take_min ? r_val : r_min_val;
        n_min_idx = take_min ? r_item.index : r_min_idx;
        if (k_zero) begin
            n_sum = r_sum;
        end else if (sum_ext > SW'(pst_pkg::SUM_MAX)) begin
            n_sum = pst_pkg::SUM_MAX;
        end else begin
            n_sum = SUMW'(sum_ext);
        end

        n_out_data.bin_value   = r_val;
        n_out_data.bin_index   = IW'(r_item.index);
        n_out_data.peak_bin    = r_item.last ? IW'(n_max_idx) : '0;
        n_out_data.floor_bin   = r_item.last ? IW'(n_min_idx) : '0;
        n_out_data.total_power = r_item.last ? n_sum : '0;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign fire     = (r_state == S_HOLD) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_val   <= '0;
            r_max_idx   <= '0;
            r_min_val   <= pst_pkg::VALUE_MAX;
            r_min_idx   <= '0;
            r_sum       <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= head;
                        if (head.mode) begin
                            r_x     <= head.power;
                            r_res   <= '0;
                            r_bit   <= PW'(1) << (PW - 2);
                            r_state <= S_ROOT;
                        end else begin
                            r_val   <= head_sat;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_ROOT: begin
                    r_x   <= n_x;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_val   <= VW'(n_res);
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_data <= n_out_data;
                        r_out_last <= r_item.last;
                        // Clear tracking at the end of a spectrum.
                        if (r_item.last) begin
                            r_max_val <= '0;
                            r_max_idx <= '0;
                            r_min_val <= pst_pkg::VALUE_MAX;
                            r_min_idx <= '0;
                            r_sum     <= '0;
                        end else begin
                            r_max_val <= n_max_val;
                            r_max_idx <= n_max_idx;
                            r_min_val <= n_min_val;
                            r_min_idx <= n_min_idx;
                            r_sum     <= n_sum;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    `PST_ASSERT_IMPL(a_root_bit_onehot, i_clk, i_rst_n, r_state == S_ROOT, $onehot(r_bit), "root step bit not one-hot")
    `PST_ASSERT_NEXT(a_frame_clears, i_clk, i_rst_n, fire && r_item.last, (r_sum == '0) && (r_max_idx == '0) && (r_min_val == pst_pkg::VALUE_MAX), "tracking not cleared after last bin")
    `PST_ASSERT_IMPL(a_summary_zero, i_clk, i_rst_n, r_out_valid && !r_out_last, (r_out_data.peak_bin == '0) && (r_out_data.floor_bin == '0) && (r_out_data.total_power == '0), "summary fields set on non-final bin")

endmodule
`default_nettype wire

@@ rtl/core/power_spectrum_peak_tracker.sv @@
// Power spectrum peak tracker top level: front end, bin queue and back end.
//
// Takes complex FFT bins in order and returns one result per bin: the power
// re^2+im^2 (saturated to 48 bits) or, with magnitude_mode set, its floor
// square root. On the bin marked tlast, or on bin MAX_BINS-1, the result also
// carries the first peak bin, the floor bin and the saturating total power of
// bins 1..N-1, and tracking restarts. The front end takes a bin every cycle
// while the four-entry queue has room; the back end handles one bin at a
// time and takes a new bin only after it has committed the last one. In power
// mode it pops a bin from the queue and then commits it to the output
// register; in magnitude mode the square root unit resolves one result bit
// per cycle between the pop and the commit. The output register holds a
// finished result while the back end works on the next bin. Write
// magnitude_mode only when no bins are in flight.
`timescale 1ns / 1ps
`default_nettype none
module power_spectrum_peak_tracker #(
    parameter int MAX_BINS    = pst_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = pst_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // bin_re [23:0], bin_im [47:24]
    input  wire logic [pst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // last_bin
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // bin_value [47:0], bin_index [59:48], peak_bin [71:60], floor_bin [83:72],
    // total_power [143:84]
    output logic [pst_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // frame_end
    output logic                                    m_axis_tlast,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    // magnitude_mode
    input  wire logic [0:0]                         i_cfg_data
);

    localparam int ITEM_W = pst_pkg::item_width(SAMPLE_BITS, MAX_BINS);
    localparam int DEPTH  = pst_pkg::QUEUE_DEPTH;
    localparam int QCW    = $clog2(DEPTH + 1);

    logic              q_push;
    logic [ITEM_W-1:0] q_item_in;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item_out;
    logic              q_pop;
    logic [QCW-1:0]    q_count;
    pst_pkg::t_result  result;

    pst_front #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_count     (q_count),
        .o_q_push      (q_push),
        .o_q_item      (q_item_in)
    );

    pst_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_item_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item_out),
        .o_count (q_count)
    );

    pst_back #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item_out),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (result),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = result;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the power spectrum peak tracker stream block.
`timescale 1ns / 1ps
module tb_top;

    localparam int LAST_INDEX     = pst_pkg::DEF_MAX_BINS - 1;
    localparam int RANDOM_BINS    = 1830;
    localparam int DRAIN_CYCLES   = 64;
    localparam int unsigned LIMIT = 2_500_000;
    localparam int SHOWN_ERRORS   = 10;

    typedef logic [pst_pkg::SAMPLE_W-1:0] sample_t;

    typedef struct {
        pst_pkg::t_result data;
        bit               frame_end;
    } bin_expect_t;

    // Tracks spectrum state and holds the bin results still owed by the block.
    class bin_result_board;
        bit                         mag_mode;
        logic [pst_pkg::INDEX_W-1:0] bin_count;
        logic [pst_pkg::VALUE_W-1:0] peak_value;
        logic [pst_pkg::INDEX_W-1:0] peak_idx;
        logic [pst_pkg::VALUE_W-1:0] floor_value;
        logic [pst_pkg::INDEX_W-1:0] floor_idx;
        logic [pst_pkg::SUM_W-1:0]   power_total;
        bin_expect_t                 owed_bins[$];
        int unsigned                 errors;
        int unsigned                 results_seen;

        function new();
            mag_mode = 1'b0;
            errors = 0;
            results_seen = 0;
            clear_spectrum();
        endfunction

        function void clear_spectrum();
            bin_count   = '0;
            peak_value  = '0;
            peak_idx    = '0;
            floor_value = '1;
            floor_idx   = '0;
            power_total = '0;
        endfunction

        function void set_mode(bit m);
            mag_mode = m;
        endfunction

        function int pending();
            return owed_bins.size();
        endfunction

        function logic [pst_pkg::SAMPLE_W-1:0] sample_mag(sample_t s);
            return s[pst_pkg::SAMPLE_W-1] ? (~s + 1'b1) : s;
        endfunction

        // Build the root one bit at a time, keeping each bit whose square still fits.
        function logic [31:0] floor_root(logic [63:0] x);
            logic [31:0] r;
            logic [31:0] t;
            r = '0;
            for (int i = 31; i >= 0; i--) begin
                t = r | (32'd1 << i);
                if ({32'd0, t} * {32'd0, t} <= x)
                    r = t;
            end
            return r;
        endfunction

        function void note_bin(sample_t re, sample_t im, bit last_bin);
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] pwr;
            logic [63:0] headroom;
            logic [pst_pkg::VALUE_W-1:0] val;
            logic [pst_pkg::INDEX_W-1:0] k;
            bit ends;
            bin_expect_t e;
            a = {40'd0, sample_mag(re)};
            b = {40'd0, sample_mag(im)};
            pwr = a * a + b * b;
            k = bin_count;
            ends = last_bin || (k >= LAST_INDEX);
            if (mag_mode)
                val = {16'd0, floor_root(pwr)};
            else
                val = (pwr > {16'd0, pst_pkg::VALUE_MAX}) ? pst_pkg::VALUE_MAX : pwr[47:0];

            if (k == 0 || val > peak_value) begin
                peak_value = val;
                peak_idx = k;
            end
            // Power mode keeps DC out of the floor search.
            if (mag_mode ? (k == 0 || val < floor_value)
                         : (k == 1 || (k > 1 && val < floor_value))) begin
                floor_value = val;
                floor_idx = k;
            end
            if (k != 0) begin
                headroom = {4'd0, pst_pkg::SUM_MAX} - {4'd0, power_total};
                if (pwr > headroom)
                    power_total = pst_pkg::SUM_MAX;
                else
                    power_total = power_total + pwr[59:0];
            end

            e.data = '0;
            e.data.bin_value = val;
            e.data.bin_index = k;
            e.frame_end = ends;
            if (ends) begin
                e.data.peak_bin = peak_idx;
                e.data.floor_bin = floor_idx;
                e.data.total_power = power_total;
                clear_spectrum();
            end else begin
                bin_count = k + 1'b1;
            end
            owed_bins.push_back(e);
        endfunction

        function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("result %0d: %s mismatch, expected %0h, got %0h",
                         results_seen, what, exp_v, act_v);
        endfunction

        function void check_result(pst_pkg::t_result r, logic frame_end);
            bin_expect_t e;
            results_seen++;
            if (owed_bins.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("result %0d: transfer with no result outstanding, data %0h",
                             results_seen, r);
                return;
            end
            e = owed_bins.pop_front();
            if (r.bin_value !== e.data.bin_value)
                flag("bin_value", 64'(e.data.bin_value), 64'(r.bin_value));
            if (r.bin_index !== e.data.bin_index)
                flag("bin_index", 64'(e.data.bin_index), 64'(r.bin_index));
            if (frame_end !== e.frame_end)
                flag("frame_end", 64'(e.frame_end), 64'(frame_end));
            if (r.peak_bin !== e.data.peak_bin)
                flag("peak_bin", 64'(e.data.peak_bin), 64'(r.peak_bin));
            if (r.floor_bin !== e.data.floor_bin)
                flag("floor_bin", 64'(e.data.floor_bin), 64'(r.floor_bin));
            if (r.total_power !== e.data.total_power)
                flag("total_power", 64'(e.data.total_power), 64'(r.total_power));
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [pst_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                               s_axis_tlast;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [pst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [0:0]                         i_cfg_data;

    bin_result_board board;
    bit              src_steady;
    bit              sink_steady;
    bit              mode_now;
    int unsigned     cycle_count;

    power_spectrum_peak_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly random full-scale samples, with extremes and tiny values for ties.
    function automatic sample_t draw_sample();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                case ($urandom_range(0, 4))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    3: return 24'hFFFFFF;
                    default: return 24'h000001;
                endcase
            end
            1, 2, 3: return sample_t'($urandom_range(0, 7)) - 24'd4;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_bin(sample_t re, sample_t im, bit last_bin);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        s_axis_tlast  <= last_bin;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_bin(re, im, last_bin);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_mode(m);
        mode_now = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result sink: random stalls between transfers, checked at the rising edge.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 19);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(pst_pkg::t_result'(m_axis_tdata), m_axis_tlast);
        end
    end

    initial begin
        int len;
        int split;
        int sent;
        board = new();
        cycle_count = 0;
        src_steady = 1'b0;
        sink_steady = 1'b0;
        mode_now = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Power mode: a spectrum of one bin reports floor bin zero.
        write_mode(1'b0);
        send_bin(24'h7FFFFF, 24'h800000, 1'b1);
        // Peak ties go to DC, floor ties to the first non-DC bin.
        send_bin(24'h800000, 24'h800000, 1'b0);
        send_bin(24'h000000, 24'h000000, 1'b0);
        send_bin(24'h000001, 24'h000000, 1'b0);
        send_bin(24'h000000, 24'hFFFFFF, 1'b0);
        send_bin(24'h800000, 24'h800000, 1'b0);
        send_bin(24'h000000, 24'h000000, 1'b1);
        // DC smallest but excluded from floor and total.
        send_bin(24'h000000, 24'h000000, 1'b0);
        send_bin(24'h000003, 24'h000004, 1'b0);
        send_bin(24'h000005, 24'h000000, 1'b0);
        send_bin(24'h7FFFFF, 24'h7FFFFF, 1'b1);
        // Switch to magnitude mode in the middle of a spectrum.
        send_bin(24'h000002, 24'h000002, 1'b0);
        send_bin(24'h000006, 24'h000008, 1'b0);
        wait_idle();
        write_mode(1'b1);
        send_bin(24'h000006, 24'h000008, 1'b0);
        send_bin(24'h800000, 24'h800000, 1'b1);
        // Magnitude mode: DC takes part in the floor.
        send_bin(24'h000000, 24'h000000, 1'b1);
        send_bin(24'h000000, 24'h000000, 1'b0);
        send_bin(24'h000001, 24'h000001, 1'b0);
        send_bin(24'hFFFFFF, 24'h000000, 1'b1);

        sent = 0;
        while (sent < RANDOM_BINS) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                write_mode(1'($urandom_range(0, 1)));
                src_steady = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
            split = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (split != 0 && i == split) begin
                    wait_idle();
                    write_mode(!mode_now);
                end
                send_bin(draw_sample(), draw_sample(), i == len - 1);
            end
            sent += len;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pst_pkg.sv
rtl/core/pst_queue.sv
rtl/core/pst_front.sv
rtl/core/pst_back.sv
rtl/core/power_spectrum_peak_tracker.sv
test/tb_top.sv
